/* rtl/fisr_pkg.sv */
// Package for the fast inverse square root pipeline: constants, pipeline record types and
// the binary32 multiply and add step functions used by the stages of the top level.
// Depends on nothing.
package fisr_pkg;

  localparam logic [31:0] SEED_MAGIC   = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF     = 32'h3f000000;
  localparam logic [31:0] THREE_HALVES = 32'h3fc00000;
  localparam logic [31:0] QUIET_BIT    = 32'h00400000;
  localparam int unsigned PIPE_DEPTH   = 10;

  // Multiplier state between the product stage and the round stage.
  typedef struct packed {
    logic               sign;
    logic               inf;
    logic               zero;
    logic signed [10:0] exp;
    logic [47:0]        prod;
  } mul_mid_t;

  // Adder state between the align/add stage and the normalize/round stage.
  typedef struct packed {
    logic        sign;
    logic        inf;
    logic [8:0]  exp;
    logic [27:0] sum;
  } add_mid_t;

  // Values that travel beside the arithmetic: the seed, or the quieted NaN when nan is set.
  typedef struct packed {
    logic        nan;
    logic [31:0] y;
  } side_t;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] lz;
    lz = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (m[i]) lz = 5'(23 - i);
    end
    return lz;
  endfunction

  function automatic logic [4:0] lzc27(input logic [26:0] m);
    logic [4:0] lz;
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (m[i]) lz = 5'(26 - i);
    end
    return lz;
  endfunction

  function automatic logic [31:0] seed_of(input logic [31:0] x);
    logic [31:0] half_shift;
    half_shift = {x[31], x[31:1]};
    return SEED_MAGIC - half_shift;
  endfunction

  function automatic logic is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hff) && (x[22:0] != 23'd0);
  endfunction

  // First half of a multiply: unpack, normalize subnormals, form the exact product.
  function automatic mul_mid_t mul_a(input logic [31:0] a, input logic [31:0] b);
    mul_mid_t           r;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [4:0]         lza;
    logic [4:0]         lzb;
    logic signed [10:0] ea;
    logic signed [10:0] eb;
    ma  = {a[30:23] != 8'd0, a[22:0]};
    mb  = {b[30:23] != 8'd0, b[22:0]};
    lza = lzc24(ma);
    lzb = lzc24(mb);
    ea  = $signed({3'b000, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}) - $signed({6'd0, lza});
    eb  = $signed({3'b000, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}) - $signed({6'd0, lzb});
    r.sign = a[31] ^ b[31];
    r.inf  = (a[30:23] == 8'hff) || (b[30:23] == 8'hff);
    r.zero = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
    r.exp  = ea + eb - 11'sd127;
    r.prod = 48'(ma << lza) * 48'(mb << lzb);
    return r;
  endfunction

  // Second half of a multiply: one-bit normalize, subnormal shift, round to nearest even.
  function automatic logic [31:0] mul_b(input mul_mid_t r);
    logic [47:0]        m48;
    logic [47:0]        ms;
    logic signed [10:0] e;
    logic [10:0]        sh;
    logic               st;
    logic               rnd;
    logic [7:0]         ef;
    logic [23:0]        mant;
    logic [30:0]        packed_v;
    if (r.inf) return {r.sign, 8'hff, 23'd0};
    if (r.zero) return {r.sign, 31'd0};
    m48 = r.prod[47] ? r.prod : {r.prod[46:0], 1'b0};
    e   = r.prod[47] ? r.exp + 11'sd1 : r.exp;
    if (e >= 11'sd255) return {r.sign, 8'hff, 23'd0};
    if (e < 11'sd1) begin
      sh = 11'(11'sd1 - e);
      ef = 8'd0;
      if (sh >= 11'd48) begin
        ms = 48'd0;
        st = |m48;
      end else begin
        ms = m48 >> sh[5:0];
        st = |(m48 & ~({48{1'b1}} << sh[5:0]));
      end
    end else begin
      ms = m48;
      st = 1'b0;
      ef = e[7:0];
    end
    mant     = ms[47:24];
    rnd      = ms[23];
    st       = st | (|ms[22:0]);
    packed_v = {ef, mant[22:0]} + 31'(rnd & (st | mant[0]));
    return {r.sign, packed_v};
  endfunction

  // First half of an add: order by magnitude, align with sticky, add or subtract.
  function automatic add_mid_t add_a(input logic [31:0] a, input logic [31:0] b);
    add_mid_t    r;
    logic [31:0] big;
    logic [31:0] sml;
    logic [26:0] mb27;
    logic [26:0] ms27;
    logic [26:0] sh27;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic        st;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d    = eb - es;
    mb27 = {big[30:23] != 8'd0, big[22:0], 3'b000};
    ms27 = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    if (d >= 8'd27) begin
      sh27 = 27'd0;
      st   = |ms27;
    end else begin
      sh27 = ms27 >> d[4:0];
      st   = |(ms27 & ~({27{1'b1}} << d[4:0]));
    end
    sh27[0] = sh27[0] | st;
    r.sign = big[31];
    r.inf  = (big[30:23] == 8'hff);
    r.exp  = {1'b0, eb};
    r.sum  = (big[31] ^ sml[31]) ? {1'b0, mb27} - {1'b0, sh27} : {1'b0, mb27} + {1'b0, sh27};
    return r;
  endfunction

  // Second half of an add: normalize (not below the smallest exponent) and round.
  function automatic logic [31:0] add_b(input add_mid_t r);
    logic [26:0] n;
    logic [8:0]  e;
    logic [4:0]  lz;
    logic [8:0]  sh;
    logic [7:0]  ef;
    logic [23:0] mant;
    logic        rnd;
    logic        st;
    logic [30:0] packed_v;
    if (r.inf) return {r.sign, 8'hff, 23'd0};
    if (r.sum == 28'd0) return 32'd0;
    if (r.sum[27]) begin
      n = {r.sum[27:2], r.sum[1] | r.sum[0]};
      e = r.exp + 9'd1;
    end else begin
      lz = lzc27(r.sum[26:0]);
      sh = ({4'd0, lz} < (r.exp - 9'd1)) ? {4'd0, lz} : (r.exp - 9'd1);
      n  = r.sum[26:0] << sh[4:0];
      e  = r.exp - sh;
    end
    if (e >= 9'd255) return {r.sign, 8'hff, 23'd0};
    ef       = n[26] ? e[7:0] : 8'd0;
    mant     = n[26:3];
    rnd      = n[2];
    st       = |n[1:0];
    packed_v = {ef, mant[22:0]} + 31'(rnd & (st | mant[0]));
    return {r.sign, packed_v};
  endfunction

endpackage

/* rtl/fast_inverse_square_root.sv */
// Top level of the fast inverse square root pipeline: seed, one Newton step, binary32 math.
// Depends on fisr_pkg for constants, record types and the multiply and add step functions.
//
// Takes one binary32 pattern per item and returns 0x5f3759df-seeded y*(1.5-(x/2*y)*y) in
// binary32, round to nearest even with subnormals. The datapath is ten register stages: each
// of the four multiplies takes a product stage and a round stage, the subtraction takes an
// align stage and a normalize stage. An item can enter every cycle unless a waiting output item holds the pipeline.
// The whole pipeline holds while the output item waits, so a stall loses nothing.
module fast_inverse_square_root (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] number_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] result_bits
);

  localparam int unsigned DEPTH = fisr_pkg::PIPE_DEPTH;

  logic                    en;
  logic [DEPTH-1:0]        vld;
  fisr_pkg::side_t         side [DEPTH];
  fisr_pkg::side_t         side_in;
  fisr_pkg::mul_mid_t      mm_x2;
  fisr_pkg::mul_mid_t      mm_t1;
  fisr_pkg::mul_mid_t      mm_t2;
  fisr_pkg::mul_mid_t      mm_y;
  fisr_pkg::add_mid_t      am_s;
  logic [31:0]             x2;
  logic [31:0]             t1;
  logic [31:0]             t2;
  logic [31:0]             s;
  logic [31:0]             res;
  logic [31:0]             seed_in;

  assign en       = !vld[DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = res;

  // A NaN input wins over a NaN seed; either one is carried beside the math and chosen at the end.
  always_comb begin
    seed_in = fisr_pkg::seed_of(s_tdata);
    if (fisr_pkg::is_nan(s_tdata)) begin
      side_in.nan = 1'b1;
      side_in.y   = s_tdata | fisr_pkg::QUIET_BIT;
    end else if (fisr_pkg::is_nan(seed_in)) begin
      side_in.nan = 1'b1;
      side_in.y   = seed_in | fisr_pkg::QUIET_BIT;
    end else begin
      side_in.nan = 1'b0;
      side_in.y   = seed_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < DEPTH; i++) begin
        side[i] <= side[i-1];
      end
      mm_x2 <= fisr_pkg::mul_a(s_tdata, fisr_pkg::ONE_HALF);
      x2    <= fisr_pkg::mul_b(mm_x2);
      mm_t1 <= fisr_pkg::mul_a(x2, side[1].y);
      t1    <= fisr_pkg::mul_b(mm_t1);
      mm_t2 <= fisr_pkg::mul_a(t1, side[3].y);
      t2    <= fisr_pkg::mul_b(mm_t2);
      am_s  <= fisr_pkg::add_a(fisr_pkg::THREE_HALVES, {~t2[31], t2[30:0]});
      s     <= fisr_pkg::add_b(am_s);
      mm_y  <= fisr_pkg::mul_a(side[7].y, s);
      res   <= side[8].nan ? side[8].y : fisr_pkg::mul_b(mm_y);
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted item did not enter the pipeline");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_stall_holds_side: assert property (@(posedge clk) disable iff (rst)
    !en && vld[DEPTH-1] |=> $stable(side[DEPTH-1]))
    else $error("last stage side data moved during a stall");

endmodule

/* verif/fast_inverse_square_root_tb.sv */
// Testbench for the fast inverse square root pipeline: streams binary32 patterns through
// the block with random gaps and stalls and checks every result against a local predictor.
// Depends on the RTL top level fast_inverse_square_root only.
`timescale 1ns / 1ps

module fast_inverse_square_root_tb;

  localparam logic [31:0] SEED_CONST  = 32'h5f3759df;
  localparam logic [31:0] QUIET_MASK  = 32'h00400000;
  localparam int          ITEM_COUNT  = 650;
  localparam int          DRAIN_WAIT  = 30;
  localparam int          HOLD_AT     = 200;
  localparam int          HOLD_CYCLES = 80;

  class rsqrt_scoreboard;
    logic [31:0] pending_results[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function automatic logic is_nan32(logic [31:0] b);
      return (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
    endfunction

    // Widens a binary32 pattern to a real; every binary32 value is exact in double.
    function automatic real to_real(logic [31:0] b);
      logic [10:0] e64;
      if (b[30:23] == 8'hff) return $bitstoreal({b[31], 11'h7ff, 52'd0});
      if (b[30:23] == 8'd0) begin
        if (b[31]) return -(real'(b[22:0]) * (2.0 ** -149));
        return real'(b[22:0]) * (2.0 ** -149);
      end
      e64 = 11'(b[30:23]) + 11'd896;
      return $bitstoreal({b[31], e64, b[22:0], 29'd0});
    endfunction

    // Rounds a real to binary32, nearest even, with subnormals.
    function automatic logic [31:0] to_bin32(real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] kept;
      logic [63:0] lost;
      int          fexp;
      int          drop;
      logic [7:0]  ef;
      logic        rnd;
      logic        sticky;
      logic [30:0] mag;
      d = $realtobits(r);
      if (d[62:52] == 11'h7ff) return {d[63], 8'hff, 23'd0};
      if (d[62:52] == 11'd0) return {d[63], 31'd0};
      fexp = int'(d[62:52]) - 1023 + 127;
      if (fexp >= 255) return {d[63], 8'hff, 23'd0};
      m = {11'd1, d[51:0]};
      drop = (fexp >= 1) ? 29 : 29 + 1 - fexp;
      if (drop > 60) return {d[63], 31'd0};
      ef     = (fexp >= 1) ? 8'(fexp) : 8'd0;
      kept   = m >> drop;
      lost   = m & ~({64{1'b1}} << drop);
      rnd    = lost[drop-1];
      sticky = (lost & ~({64{1'b1}} << (drop - 1))) != 64'd0;
      mag    = {ef, kept[22:0]} + 31'(rnd & (sticky | kept[0]));
      return {d[63], mag};
    endfunction

    function automatic logic [31:0] rsqrt_estimate(logic [31:0] x);
      logic [31:0] seed;
      logic [31:0] half_x;
      logic [31:0] t;
      if (is_nan32(x)) return x | QUIET_MASK;
      seed = SEED_CONST - {x[31], x[31:1]};
      if (is_nan32(seed)) return seed | QUIET_MASK;
      half_x = to_bin32(to_real(x) * 0.5);
      t = to_bin32(to_real(half_x) * to_real(seed));
      t = to_bin32(to_real(t) * to_real(seed));
      t = to_bin32(1.5 - to_real(t));
      return to_bin32(to_real(seed) * to_real(t));
    endfunction

    function void note_operand(logic [31:0] x);
      pending_results.insert(pending_results.size(), rsqrt_estimate(x));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (pending_results.size() == 0) begin
        $error("result_bits: unexpected item, actual %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        $error("result_bits: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  rsqrt_scoreboard sb;
  bit              quiet_gaps;
  int              results_seen;

  fast_inverse_square_root u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial sb = new();

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_operand(s_tdata);
    if (!rst && m_tvalid && m_tready) begin
      sb.check_result(m_tdata);
      results_seen++;
    end
  end

  task automatic send_operand(logic [31:0] x);
    int gap;
    gap = quiet_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 5))
      0, 1: v[31] = 1'b0;                              // positive, any exponent
      2:    v = {1'b0, 8'd0, v[22:0]};                 // positive subnormal
      3:    v = {1'b0, 8'($urandom_range(100, 160)), v[22:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Receiver: random stalls, one long hold so the pipeline backs up into the input.
  initial begin
    int  n;
    bit  held;
    held = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && results_seen >= HOLD_AT) begin
        held = 1;
        n = HOLD_CYCLES;
      end else begin
        n = quiet_gaps ? 0 : $urandom_range(0, 4);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    logic [31:0] directed[] = '{
      32'h00000000, 32'h80000000, 32'h00000001, 32'h007fffff, 32'h00800000,
      32'h3f800000, 32'h40800000, 32'h7f7fffff, 32'h7f800000, 32'hff800000,
      32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'hffc00001, 32'hbf800000,
      32'h807fffff, 32'hbeeeb3be, 32'hbeeeb3bf, 32'h3e800000, 32'h5f3759df,
      32'h55555555, 32'haaaaaaaa};
    results_seen = 0;
    quiet_gaps = 0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_operand(directed[i]);
    for (int i = 0; i < ITEM_COUNT; i++) begin
      // Back-to-back stretches with no idling on either side.
      quiet_gaps = (i % 150) >= 120;
      send_operand(random_operand());
    end
    quiet_gaps = 0;
    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0) $display("fast_inverse_square_root_tb: clean");
    else $display("fast_inverse_square_root_tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("fast_inverse_square_root_tb: errors");
    $finish;
  end

endmodule
